// ===== sv/evte_pkg.sv =====
// ----------------------------------------------------------------------------
// evte_pkg
// shared types and codes of the energy voice turn endpointer
// ----------------------------------------------------------------------------
package evte_pkg;

	localparam int FUNC_W   = 3;
	localparam int SAMPLE_W = 16;
	localparam int THR_W    = 15;
	localparam int TICK_W   = 16;
	localparam int MARGIN_W = 27;
	localparam int DELTA_W  = 18;
	localparam int CAUSE_W  = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [FUNC_W-1:0] FUNC_SAMPLE    = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_TICK      = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_START     = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_STOP      = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_CANCEL    = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_LINK_UP   = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_LINK_DOWN = 3'd6;

	localparam logic [CAUSE_W-1:0] CAUSE_NONE    = 2'd0;
	localparam logic [CAUSE_W-1:0] CAUSE_SILENCE = 2'd1;
	localparam logic [CAUSE_W-1:0] CAUSE_LIMIT   = 2'd2;
	localparam logic [CAUSE_W-1:0] CAUSE_MANUAL  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 2'd2;

	localparam logic [THR_W-1:0]  THRESHOLD_RST = 15'd600;
	localparam logic [TICK_W-1:0] HOLD_RST      = 16'd900;
	localparam logic [TICK_W-1:0] LIMIT_RST     = 16'd15000;

	localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
	localparam logic signed [MARGIN_W-1:0] MARGIN_MAX = {1'b0, {(MARGIN_W-1){1'b1}}};
	localparam logic signed [MARGIN_W-1:0] MARGIN_MIN = {1'b1, {(MARGIN_W-1){1'b0}}};

	localparam int OPQ_DEPTH = 4;
	localparam int OPQ_AW    = $clog2(OPQ_DEPTH);
	localparam int OPQ_CW    = $clog2(OPQ_DEPTH + 1);
	localparam int RSQ_DEPTH = 2;
	localparam int RSQ_AW    = $clog2(RSQ_DEPTH);
	localparam int RSQ_CW    = $clog2(RSQ_DEPTH + 1);

	typedef struct packed {
		logic [FUNC_W-1:0]         func;
		logic                      last;
		logic signed [DELTA_W-1:0] delta;
	} op_t;

	typedef struct packed {
		logic               is_listening;
		logic               speech_seen;
		logic               link_ok;
		logic               turn_began;
		logic               turn_ended;
		logic [CAUSE_W-1:0] end_cause;
	} res_t;

	typedef struct packed {
		logic [TICK_W-1:0] silence_hold;
		logic [TICK_W-1:0] turn_limit;
	} timer_cfg_t;

endpackage

// ===== sv/evte_front.sv =====
// ----------------------------------------------------------------------------
// evte_front
// accepts items, forms the per-sample margin step and queues decoded operations
// ----------------------------------------------------------------------------
module evte_front import evte_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [FUNC_W-1:0]          func,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       block_end,
	input  logic [THR_W-1:0]           threshold,
	output logic                       op_valid,
	output op_t                        op_head,
	input  logic                       op_take
);

	op_t              opq_q [OPQ_DEPTH];
	logic [OPQ_AW-1:0] wr_ptr_q;
	logic [OPQ_AW-1:0] rd_ptr_q;
	logic [OPQ_CW-1:0] cnt_q;

	logic              accept;
	logic              take;
	logic [SAMPLE_W:0] mag;
	op_t               op_new;

	assign full     = (cnt_q == OPQ_CW'(OPQ_DEPTH));
	assign op_valid = (cnt_q != '0);
	assign op_head  = opq_q[rd_ptr_q];
	assign accept   = push && !full;
	assign take     = op_take && op_valid;

	// magnitude of the sample, 32768 included
	always_comb begin
		if (sample[SAMPLE_W-1]) begin
			mag = (SAMPLE_W+1)'(0) - {sample[SAMPLE_W-1], sample};
		end else begin
			mag = {1'b0, sample};
		end
		op_new.func  = func;
		op_new.last  = block_end;
		op_new.delta = DELTA_W'(signed'({1'b0, mag}))
			- DELTA_W'(signed'({1'b0, threshold})) - DELTA_W'(1);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opq_q[wr_ptr_q] <= op_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + OPQ_AW'(1);
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + OPQ_AW'(1);
			end
			cnt_q <= cnt_q + OPQ_CW'(accept) - OPQ_CW'(take);
		end
	end

endmodule

// ===== sv/evte_back.sv =====
// ----------------------------------------------------------------------------
// evte_back
// turn state, energy margin and timers, with the result queue
// ----------------------------------------------------------------------------
module evte_back import evte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       op_valid,
	input  op_t        op_head,
	output logic       op_take,
	input  timer_cfg_t tcfg,
	output logic       empty,
	input  logic       pop,
	output res_t       res_head
);

	logic                       link_q;
	logic                       listen_q;
	logic                       speech_q;
	logic signed [MARGIN_W-1:0] margin_q;
	logic [TICK_W-1:0]          silence_q;
	logic [TICK_W-1:0]          turn_q;

	res_t              rsq_q [RSQ_DEPTH];
	logic [RSQ_AW-1:0] wr_ptr_q;
	logic [RSQ_AW-1:0] rd_ptr_q;
	logic [RSQ_CW-1:0] cnt_q;

	logic                       exec;
	logic                       take_res;
	logic                       link_d;
	logic                       listen_d;
	logic                       speech_d;
	logic signed [MARGIN_W-1:0] margin_d;
	logic [TICK_W-1:0]          silence_d;
	logic [TICK_W-1:0]          turn_d;
	logic                       began;
	logic [CAUSE_W-1:0]         cause;
	logic signed [MARGIN_W:0]   sum;
	logic signed [MARGIN_W-1:0] sum_sat;
	res_t                       res_new;

	assign exec     = op_valid && (cnt_q != RSQ_CW'(RSQ_DEPTH));
	assign op_take  = exec;
	assign empty    = (cnt_q == '0);
	assign take_res = pop && !empty;
	assign res_head = rsq_q[rd_ptr_q];

	// saturating margin step
	always_comb begin
		sum = {margin_q[MARGIN_W-1], margin_q}
			+ (MARGIN_W+1)'(op_head.delta);
		if (sum[MARGIN_W] != sum[MARGIN_W-1]) begin
			sum_sat = sum[MARGIN_W] ? MARGIN_MIN : MARGIN_MAX;
		end else begin
			sum_sat = sum[MARGIN_W-1:0];
		end
	end

	always_comb begin
		link_d    = link_q;
		listen_d  = listen_q;
		speech_d  = speech_q;
		margin_d  = margin_q;
		silence_d = silence_q;
		turn_d    = turn_q;
		began     = 1'b0;
		cause     = CAUSE_NONE;
		unique case (op_head.func)
			FUNC_SAMPLE: begin
				if (listen_q && link_q) begin
					margin_d = sum_sat;
					if (op_head.last) begin
						if (!sum_sat[MARGIN_W-1]) begin
							speech_d  = 1'b1;
							silence_d = '0;
						end else if (speech_q && (silence_q > tcfg.silence_hold)) begin
							cause = CAUSE_SILENCE;
						end
						margin_d = '0;
					end
				end
			end
			FUNC_TICK: begin
				if (listen_q) begin
					turn_d    = (turn_q == TICK_MAX) ? TICK_MAX : turn_q + TICK_W'(1);
					silence_d = (silence_q == TICK_MAX) ? TICK_MAX : silence_q + TICK_W'(1);
					if (turn_d > tcfg.turn_limit) begin
						cause = CAUSE_LIMIT;
					end
				end
			end
			FUNC_START: begin
				if (link_q && !listen_q) begin
					listen_d  = 1'b1;
					speech_d  = 1'b0;
					margin_d  = '0;
					silence_d = '0;
					turn_d    = '0;
					began     = 1'b1;
				end
			end
			FUNC_STOP: begin
				if (listen_q) begin
					cause = CAUSE_MANUAL;
				end
			end
			FUNC_CANCEL: begin
				listen_d = 1'b0;
			end
			FUNC_LINK_UP: begin
				link_d = 1'b1;
			end
			FUNC_LINK_DOWN: begin
				link_d   = 1'b0;
				listen_d = 1'b0;
			end
			default: begin
			end
		endcase
		if (cause != CAUSE_NONE) begin
			listen_d = 1'b0;
		end
		res_new.is_listening = listen_d;
		res_new.speech_seen  = speech_d;
		res_new.link_ok      = link_d;
		res_new.turn_began   = began;
		res_new.turn_ended   = (cause != CAUSE_NONE);
		res_new.end_cause    = cause;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q    <= 1'b0;
			listen_q  <= 1'b0;
			speech_q  <= 1'b0;
			margin_q  <= '0;
			silence_q <= '0;
			turn_q    <= '0;
		end else if (exec) begin
			link_q    <= link_d;
			listen_q  <= listen_d;
			speech_q  <= speech_d;
			margin_q  <= margin_d;
			silence_q <= silence_d;
			turn_q    <= turn_d;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			rsq_q[wr_ptr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (exec) begin
				wr_ptr_q <= wr_ptr_q + RSQ_AW'(1);
			end
			if (take_res) begin
				rd_ptr_q <= rd_ptr_q + RSQ_AW'(1);
			end
			cnt_q <= cnt_q + RSQ_CW'(exec) - RSQ_CW'(take_res);
		end
	end

endmodule

// ===== sv/energy_vad_turn_endpointer.sv =====
// ----------------------------------------------------------------------------
// energy_vad_turn_endpointer
// energy voice activity detector that ends a listening turn on silence after
// speech, on a turn limit or on a manual stop
//
// channel   direction  handshake              payload
// input     in         push / full            func, sample, block_end
// result    out        empty / pop            is_listening .. end_cause
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one item per cycle sustained while neither queue is full; a result passes
// through the operation queue and then the result queue before it is on the ports
// a four-entry operation queue parts front from back, a two-entry result
// queue parts the back from the consumer; each side stalls on its own
// reset clears turn state, timers, margin, queues and loads register defaults
// ----------------------------------------------------------------------------
module energy_vad_turn_endpointer import evte_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [FUNC_W-1:0]          func,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       block_end,
	output logic                       empty,
	input  logic                       pop,
	output logic                       is_listening,
	output logic                       speech_seen,
	output logic                       link_ok,
	output logic                       turn_began,
	output logic                       turn_ended,
	output logic [CAUSE_W-1:0]         end_cause,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	logic [THR_W-1:0]  threshold_q;
	logic [TICK_W-1:0] hold_q;
	logic [TICK_W-1:0] limit_q;

	logic       op_valid;
	op_t        op_head;
	logic       op_take;
	timer_cfg_t tcfg;
	res_t       res_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			hold_q      <= HOLD_RST;
			limit_q     <= LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_THRESHOLD: threshold_q <= cfg_data[THR_W-1:0];
				REG_HOLD:      hold_q      <= cfg_data[TICK_W-1:0];
				REG_LIMIT:     limit_q     <= cfg_data[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign tcfg.silence_hold = hold_q;
	assign tcfg.turn_limit   = limit_q;

	evte_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.func      (func),
		.sample    (sample),
		.block_end (block_end),
		.threshold (threshold_q),
		.op_valid  (op_valid),
		.op_head   (op_head),
		.op_take   (op_take)
	);

	evte_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_head  (op_head),
		.op_take  (op_take),
		.tcfg     (tcfg),
		.empty    (empty),
		.pop      (pop),
		.res_head (res_head)
	);

	assign is_listening = res_head.is_listening;
	assign speech_seen  = res_head.speech_seen;
	assign link_ok      = res_head.link_ok;
	assign turn_began   = res_head.turn_began;
	assign turn_ended   = res_head.turn_ended;
	assign end_cause    = res_head.end_cause;

endmodule
